### rtl/postfix_stack_evaluator_assert.svh
// assertion helpers for the postfix evaluator
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pse: check failed");

// next-cycle implication
`define PSE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pse: check failed");

`endif

### rtl/pse_pkg.sv
`default_nettype none

package pse_pkg;

	localparam int VAL_W     = 48;
	localparam int HALF_W    = VAL_W / 2;
	localparam int MAG_W     = 2 * VAL_W;
	localparam int MUL_STEPS = 4;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_OPER = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MALFORMED = 3'd1;
	localparam logic [2:0] ST_LEFTOVER  = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_DIVZERO   = 3'd4;

	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic dz;
	} alu_rsp_t;

endpackage

`default_nettype wire

### rtl/pse_tok_if.sv
`default_nettype none

interface pse_tok_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        kind;
	logic [1:0]                        op;
	logic signed [pse_pkg::VAL_W-1:0]  value;

	modport source (output valid, output kind, output op, output value, input ready);
	modport sink (input valid, input kind, input op, input value, output ready);
endinterface

`default_nettype wire

### rtl/pse_rsp_if.sv
`default_nettype none

interface pse_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [pse_pkg::VAL_W-1:0]  result;
	logic [2:0]                        status;

	modport source (output valid, output result, output status, input ready);
	modport sink (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

### rtl/pse_ram.sv
`default_nettype none

module pse_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

### rtl/pse_alu.sv
`default_nettype none

module pse_alu #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pse_pkg::alu_req_t                req,
	input  logic signed [pse_pkg::VAL_W-1:0] a,
	input  logic signed [pse_pkg::VAL_W-1:0] b,
	output pse_pkg::alu_rsp_t                rsp,
	output logic signed [pse_pkg::VAL_W-1:0] r
);

	localparam int VW = pse_pkg::VAL_W;
	localparam int HW = pse_pkg::HALF_W;
	localparam int MW = pse_pkg::MAG_W;
	localparam int NW = VW + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	typedef enum logic [3:0] {
		AL_IDLE = 4'b0001,
		AL_MUL  = 4'b0010,
		AL_DIV  = 4'b0100,
		AL_FIN  = 4'b1000
	} alu_state_t;

	function automatic logic [VW-1:0] mag_of(input logic [VW-1:0] x);
		mag_of = x[VW-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic [VW-1:0] sat_mag(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] lim;
		lim = neg ? (MW'(1) << (VW - 1)) : ((MW'(1) << (VW - 1)) - MW'(1));
		if (m > lim) begin
			sat_mag = neg ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
		end else begin
			sat_mag = neg ? (~m[VW-1:0] + 1'b1) : m[VW-1:0];
		end
	endfunction

	function automatic logic [VW-1:0] sat_sum(input logic [VW-1:0] x, input logic [VW-1:0] y,
		input logic sub);
		logic [VW:0] s;
		s = sub ? ({x[VW-1], x} - {y[VW-1], y}) : ({x[VW-1], x} + {y[VW-1], y});
		if (s[VW] != s[VW-1]) begin
			sat_sum = s[VW] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
		end else begin
			sat_sum = s[VW-1:0];
		end
	endfunction

	alu_state_t        state_q;
	logic              done_q;
	logic              dz_q;
	logic [CW-1:0]     cnt_q;
	logic              pv_q;
	logic [1:0]        op_q;
	logic              neg_q;
	logic [VW-1:0]     ma_q;
	logic [VW-1:0]     mb_q;
	logic [2*HW-1:0]   prod_q;
	logic [1:0]        psel_q;
	logic [MW-1:0]     acc_q;
	logic [VW-1:0]     rem_q;
	logic [NW-1:0]     num_q;
	logic [VW-1:0]     r_q;

	logic [VW-1:0]     ma_c;
	logic [VW-1:0]     mb_c;
	logic              start_c;
	logic              dz_c;
	logic [HW-1:0]     pa_c;
	logic [HW-1:0]     pb_c;
	logic [VW:0]       trial_c;
	logic              ge_c;

	assign ma_c    = mag_of(a);
	assign mb_c    = mag_of(b);
	assign start_c = (state_q == AL_IDLE) && req.start;
	assign dz_c    = (req.op == pse_pkg::OP_DIV) && (mb_c == '0);

	// one 24x24 partial product per step
	assign pa_c = cnt_q[0] ? ma_q[VW-1:HW] : ma_q[HW-1:0];
	assign pb_c = cnt_q[1] ? mb_q[VW-1:HW] : mb_q[HW-1:0];

	// restoring divide, one quotient bit per step
	assign trial_c = {rem_q, num_q[NW-1]};
	assign ge_c    = trial_c >= {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AL_IDLE;
			done_q  <= 1'b0;
			dz_q    <= 1'b0;
			cnt_q   <= '0;
			pv_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				AL_IDLE: begin
					if (req.start) begin
						dz_q  <= dz_c;
						cnt_q <= '0;
						pv_q  <= 1'b0;
						case (req.op) inside
							pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
								done_q <= 1'b1;
							end
							pse_pkg::OP_MUL: begin
								state_q <= AL_MUL;
							end
							default: begin
								state_q <= dz_c ? AL_FIN : AL_DIV;
							end
						endcase
					end
				end
				AL_MUL: begin
					cnt_q <= cnt_q + CW'(1);
					pv_q  <= cnt_q < CW'(pse_pkg::MUL_STEPS);
					if (cnt_q == CW'(pse_pkg::MUL_STEPS)) begin
						state_q <= AL_FIN;
					end
				end
				AL_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NW - 1)) begin
						state_q <= AL_FIN;
					end
				end
				AL_FIN: begin
					done_q  <= 1'b1;
					state_q <= AL_IDLE;
				end
				default: begin
					state_q <= AL_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_c) begin
			op_q  <= req.op;
			neg_q <= dz_c ? a[VW-1] : (a[VW-1] ^ b[VW-1]);
			ma_q  <= ma_c;
			mb_q  <= mb_c;
			acc_q <= '0;
			rem_q <= '0;
			if (dz_c) begin
				// zero over zero gives 0, else saturate toward the dividend sign
				num_q <= (ma_c == '0) ? '0 : '1;
			end else begin
				num_q <= NW'(ma_c) << FRAC_BITS;
			end
			r_q <= sat_sum(a, b, req.op == pse_pkg::OP_SUB);
		end
		if ((state_q == AL_MUL) && (cnt_q < CW'(pse_pkg::MUL_STEPS))) begin
			prod_q <= pa_c * pb_c;
			psel_q <= cnt_q[1:0];
		end
		if (pv_q) begin
			acc_q <= acc_q + (MW'(prod_q) << ((psel_q[0] ? HW : 0) + (psel_q[1] ? HW : 0)));
		end
		if (state_q == AL_DIV) begin
			rem_q <= ge_c ? VW'(trial_c - {1'b0, mb_q}) : trial_c[VW-1:0];
			num_q <= {num_q[NW-2:0], ge_c};
		end
		if (state_q == AL_FIN) begin
			r_q <= sat_mag(neg_q, (op_q == pse_pkg::OP_MUL) ? (acc_q >> FRAC_BITS) : MW'(num_q));
		end
	end

	assign rsp.done = done_q;
	assign rsp.dz   = dz_q;
	assign r        = r_q;

endmodule

`default_nettype wire

### rtl/postfix_stack_evaluator.sv
// push, end and ignored beats are taken straight from the idle state; an end result shows on rsp the next cycle
// operator beats pass the read and exec states; multiply sums four 24x24 partial products,
// divide forms one quotient bit per cycle, and a divide by zero skips the quotient steps
// no new beat is taken until an operator is through; the stack RAM read and the alu hold it back
// reset: stack pointer, error state and output valid clear at once; the stack RAM is not
// cleared, there is no clearing pass, entries above the stack pointer are never read
`default_nettype none

module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	pse_tok_if.sink          tok,
	pse_rsp_if.source        rsp
);

	`include "postfix_stack_evaluator_assert.svh"

	localparam int VW  = pse_pkg::VAL_W;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	// control state
	state_t            state_q;
	logic [SPW-1:0]    sp_q;
	logic [2:0]        err_q;
	logic              res_valid_q;

	// payload: top of stack lives in a register, the rest in the RAM
	logic [VW-1:0]     top_q;
	logic [1:0]        op_q;
	logic [VW-1:0]     res_result_q;
	logic [2:0]        res_status_q;

	logic              tok_acc;
	logic              sticky;
	logic              full;
	logic              push_ok;
	logic [SPW-1:0]    sp_m1;
	logic [SPW-1:0]    sp_m2;

	logic              ram_wr_en;
	logic              ram_rd_en;
	logic [VW-1:0]     ram_rd_data;

	pse_pkg::alu_req_t alu_req;
	pse_pkg::alu_rsp_t alu_rsp;
	logic signed [VW-1:0] alu_r;

	logic [VW-1:0]     end_result;
	logic [2:0]        end_status;

	// an end beat needs the output register free; everything else only needs the idle state
	assign tok.ready = (state_q == S_IDLE) &&
		(!res_valid_q || rsp.ready || (tok.kind != pse_pkg::KIND_END));
	assign tok_acc   = tok.valid && tok.ready;

	// malformed and overflow swallow the rest of the expression
	assign sticky  = (err_q == pse_pkg::ST_MALFORMED) || (err_q == pse_pkg::ST_OVERFLOW);
	assign full    = sp_q == SPW'(STACK_DEPTH);
	assign push_ok = tok_acc && (tok.kind == pse_pkg::KIND_PUSH) && !sticky && !full;
	assign sp_m1   = sp_q - SPW'(1);
	assign sp_m2   = sp_q - SPW'(2);

	// push spills the old top into the RAM; an operator fetches the entry under the top
	assign ram_wr_en = push_ok && (sp_q != '0);
	assign ram_rd_en = tok_acc && (tok.kind == pse_pkg::KIND_OPER) && !sticky &&
		(sp_q >= SPW'(2));

	pse_ram #(
		.WIDTH (VW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (sp_m1[AW-1:0]),
		.wr_data (top_q),
		.rd_en   (ram_rd_en),
		.rd_addr (sp_m2[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	// left operand comes from the RAM, right operand is the register top
	assign alu_req.start = state_q == S_READ;
	assign alu_req.op    = op_q;

	pse_alu #(
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (ram_rd_data),
		.b      (top_q),
		.rsp    (alu_rsp),
		.r      (alu_r)
	);

	// end-of-expression status
	always_comb begin
		end_result = '0;
		end_status = pse_pkg::ST_OK;
		if (sticky) begin
			end_status = err_q;
		end else if (sp_q == '0) begin
			end_status = pse_pkg::ST_MALFORMED;
		end else begin
			end_result = top_q;
			if (err_q == pse_pkg::ST_DIVZERO) begin
				end_status = pse_pkg::ST_DIVZERO;
			end else if (sp_q > SPW'(1)) begin
				end_status = pse_pkg::ST_LEFTOVER;
			end else begin
				end_status = pse_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			err_q       <= pse_pkg::ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			// a new end beat refills the output register as the old beat leaves
			if (tok_acc && (tok.kind == pse_pkg::KIND_END)) begin
				res_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tok_acc) begin
						unique case (tok.kind)
							pse_pkg::KIND_PUSH: begin
								if (!sticky) begin
									if (full) begin
										err_q <= pse_pkg::ST_OVERFLOW;
									end else begin
										sp_q <= sp_q + SPW'(1);
									end
								end
							end
							pse_pkg::KIND_OPER: begin
								if (!sticky) begin
									if (sp_q < SPW'(2)) begin
										err_q <= pse_pkg::ST_MALFORMED;
									end else begin
										state_q <= S_READ;
									end
								end
							end
							pse_pkg::KIND_END: begin
								// report and start the next expression fresh
								sp_q  <= '0;
								err_q <= pse_pkg::ST_OK;
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (alu_rsp.done) begin
						// two popped, one pushed
						state_q <= S_IDLE;
						sp_q    <= sp_m1;
						if (alu_rsp.dz && (err_q == pse_pkg::ST_OK)) begin
							err_q <= pse_pkg::ST_DIVZERO;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			top_q <= tok.value;
		end else if ((state_q == S_EXEC) && alu_rsp.done) begin
			top_q <= alu_r;
		end
		if (tok_acc) begin
			op_q <= tok.op;
		end
		if (tok_acc && (tok.kind == pse_pkg::KIND_END)) begin
			res_result_q <= end_result;
			res_status_q <= end_status;
		end
	end

	assign rsp.valid  = res_valid_q;
	assign rsp.result = res_result_q;
	assign rsp.status = res_status_q;

	// checks
	`PSE_ASSERT_IMP(a_sp_in_range, 1'b1, sp_q <= SPW'(STACK_DEPTH))
	`PSE_ASSERT_IMP(a_ram_one_access, ram_wr_en, !ram_rd_en)
	`PSE_ASSERT_NXT(a_read_then_operand, ram_rd_en, state_q == S_READ)
	`PSE_ASSERT_IMP(a_alu_done_in_exec, alu_rsp.done, state_q == S_EXEC)

endmodule

`default_nettype wire

### sim/pse_result_checker.sv
`timescale 1ns / 100ps

// watches both channels, evaluates every accepted token beat and checks each result beat
module pse_result_checker #(
	parameter int STACK_DEPTH = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	pse_tok_if   tok,
	pse_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	localparam int               VAL_W   = pse_pkg::VAL_W;
	localparam int               MAG_W   = pse_pkg::MAG_W;
	localparam logic [VAL_W-1:0] VAL_MAX = pse_pkg::VAL_MAX;
	localparam logic [VAL_W-1:0] VAL_MIN = pse_pkg::VAL_MIN;

	typedef struct packed {
		logic [VAL_W-1:0] result;
		logic [2:0]       status;
	} outcome_t;

	outcome_t         awaited[$];
	logic [VAL_W-1:0] stk[STACK_DEPTH];
	int               depth;
	logic [2:0]       err;

	function automatic logic [VAL_W-1:0] abs_val(input logic [VAL_W-1:0] x);
		return x[VAL_W-1] ? -x : x;
	endfunction

	// sign plus wide magnitude back to a saturated value
	function automatic logic [VAL_W-1:0] clamp_mag(input logic neg, input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] lim;
		lim = neg ? MAG_W'(VAL_MIN) : MAG_W'(VAL_MAX);
		if (mag > lim)
			return neg ? VAL_MIN : VAL_MAX;
		return neg ? VAL_W'(-mag) : mag[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] sat_sum(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b, input logic sub);
		logic [VAL_W:0] s;
		s = sub ? {a[VAL_W-1], a} - {b[VAL_W-1], b} : {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1])
			return s[VAL_W] ? VAL_MIN : VAL_MAX;
		return s[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] fx_product(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [MAG_W-1:0] p;
		p = (MAG_W'(abs_val(a)) * MAG_W'(abs_val(b))) >> FRAC_BITS;
		return clamp_mag(a[VAL_W-1] ^ b[VAL_W-1], p);
	endfunction

	// zero divisor saturates toward the dividend's sign; zero over zero gives 0
	function automatic logic [VAL_W-1:0] fx_quotient(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [MAG_W-1:0] q;
		if (b == '0) begin
			if (a == '0)
				return '0;
			return a[VAL_W-1] ? VAL_MIN : VAL_MAX;
		end
		q = (MAG_W'(abs_val(a)) << FRAC_BITS) / MAG_W'(abs_val(b));
		return clamp_mag(a[VAL_W-1] ^ b[VAL_W-1], q);
	endfunction

	task automatic evaluate_token(input logic [1:0] kind, input logic [1:0] op,
			input logic [VAL_W-1:0] value);
		logic             stuck;
		logic [VAL_W-1:0] lhs;
		logic [VAL_W-1:0] rhs;
		logic [VAL_W-1:0] r;
		outcome_t         res;
		stuck = (err == pse_pkg::ST_MALFORMED) || (err == pse_pkg::ST_OVERFLOW);
		case (kind)
			pse_pkg::KIND_PUSH: begin
				if (!stuck) begin
					if (depth >= STACK_DEPTH) begin
						err = pse_pkg::ST_OVERFLOW;
					end else begin
						stk[depth] = value;
						depth++;
					end
				end
			end
			pse_pkg::KIND_OPER: begin
				if (!stuck) begin
					if (depth < 2) begin
						err = pse_pkg::ST_MALFORMED;
					end else begin
						rhs = stk[depth-1];
						lhs = stk[depth-2];
						depth -= 2;
						case (op)
							pse_pkg::OP_ADD: r = sat_sum(lhs, rhs, 1'b0);
							pse_pkg::OP_SUB: r = sat_sum(lhs, rhs, 1'b1);
							pse_pkg::OP_MUL: r = fx_product(lhs, rhs);
							default: begin
								r = fx_quotient(lhs, rhs);
								if (rhs == '0 && err == pse_pkg::ST_OK)
									err = pse_pkg::ST_DIVZERO;
							end
						endcase
						stk[depth] = r;
						depth++;
					end
				end
			end
			pse_pkg::KIND_END: begin
				res.result = '0;
				if (stuck)
					res.status = err;
				else if (depth == 0)
					res.status = pse_pkg::ST_MALFORMED;
				else begin
					res.result = stk[depth-1];
					if (err == pse_pkg::ST_DIVZERO)
						res.status = pse_pkg::ST_DIVZERO;
					else if (depth > 1)
						res.status = pse_pkg::ST_LEFTOVER;
					else
						res.status = pse_pkg::ST_OK;
				end
				awaited = {awaited, res};
				depth = 0;
				err = pse_pkg::ST_OK;
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input logic [VAL_W-1:0] result, input logic [2:0] status);
		outcome_t e;
		if (awaited.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result beat with nothing pending: result %0d status %0d",
					$realtime, $signed(result), status);
		end else begin
			e = awaited.pop_front();
			if (e.result !== result || e.status !== status) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: mismatch: result exp %0d got %0d, status exp %0d got %0d",
						$realtime, $signed(e.result), $signed(result), e.status, status);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth = 0;
			err = pse_pkg::ST_OK;
			awaited.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result(rsp.result, rsp.status);
			if (tok.valid && tok.ready)
				evaluate_token(tok.kind, tok.op, tok.value);
			pending = awaited.size();
		end
	end

endmodule

### sim/tb_postfix_stack_evaluator.sv
`timescale 1ns / 100ps

// stimulus and verdict for the postfix evaluator
// the checker beside the dut does all prediction; this module only makes token beats,
// drains result beats with random stalls and decides pass or fail
module tb_postfix_stack_evaluator;

	localparam int               VAL_W   = pse_pkg::VAL_W;
	localparam logic [VAL_W-1:0] VAL_MAX = pse_pkg::VAL_MAX;
	localparam logic [VAL_W-1:0] VAL_MIN = pse_pkg::VAL_MIN;

	localparam int DEPTH        = 64;
	localparam int FRAC         = 16;
	localparam int TOKEN_GOAL   = 900;
	// longest quiet stretch: sender gap + divide + receiver stall
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 100;

	// kind code the block must ignore
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent;
	int   idle_cycles;
	bit   snd_calm;
	bit   rcv_calm;

	pse_tok_if tok();
	pse_rsp_if rsp();

	postfix_stack_evaluator #(
		.STACK_DEPTH(DEPTH),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tok(tok),
		.rsp(rsp)
	);

	pse_result_checker #(
		.STACK_DEPTH(DEPTH),
		.FRAC_BITS(FRAC)
	) result_chk (
		.clk(clk),
		.arst_n(arst_n),
		.tok(tok),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// whole number n in fixed point
	function automatic logic [VAL_W-1:0] q_int(input int n);
		longint s;
		s = longint'(n) <<< FRAC;
		return s[VAL_W-1:0];
	endfunction

	// operand mix: zero, both extremes, one lsb, modest values and raw bit patterns
	function automatic logic [VAL_W-1:0] pick_value();
		longint s;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return VAL_MAX;
			2: return VAL_MIN;
			3: return ($urandom_range(0, 1) == 1) ? VAL_W'(1) : '1;
			4, 5, 6: begin
				s = longint'($urandom_range(0, 400)) - 200;
				s = (s <<< FRAC) + longint'($urandom_range(0, (1 << FRAC) - 1));
				return s[VAL_W-1:0];
			end
			default: return VAL_W'({$urandom(), $urandom()});
		endcase
	endfunction

	// one token beat: optional gap with valid low, then hold until accepted
	task automatic put_token(input logic [1:0] kind, input logic [1:0] op,
			input logic [VAL_W-1:0] value);
		int gap;
		gap = snd_calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			tok.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tok.valid <= 1'b1;
		tok.kind  <= kind;
		tok.op    <= op;
		tok.value <= value;
		do @(posedge clk); while (!(tok.valid && tok.ready));
		@(negedge clk);
		if (kind != KIND_UNUSED)
			sent++;
	endtask

	// unused fields carry random bits so every input bit toggles
	task automatic push_value(input logic [VAL_W-1:0] v);
		put_token(pse_pkg::KIND_PUSH, 2'($urandom), v);
	endtask

	task automatic apply_op(input logic [1:0] op);
		put_token(pse_pkg::KIND_OPER, op, pick_value());
	endtask

	task automatic end_expr();
		put_token(pse_pkg::KIND_END, 2'($urandom), pick_value());
	endtask

	// drop valid and wait until every pending result beat has been taken
	task automatic hold_off();
		tok.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// valid postfix with random operands; keep > 1 leaves operands over at the end
	task automatic well_formed_expr(input int operands, input int keep);
		int depth;
		int left;
		depth = 0;
		left  = operands;
		while (left > 0 || depth > keep) begin
			if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				push_value(pick_value());
				depth++;
				left--;
			end else begin
				apply_op(2'($urandom_range(0, 3)));
				depth--;
			end
		end
		end_expr();
	endtask

	// fill the stack to the brim, or past it, then fold some of it back
	task automatic full_stack_expr(input int extra);
		repeat (DEPTH + extra) push_value(pick_value());
		repeat ($urandom_range(0, DEPTH - 1)) apply_op(2'($urandom_range(0, 3)));
		end_expr();
	endtask

	// random kinds in any order, unused kind included: mostly underflows
	task automatic noise_expr(input int len);
		repeat (len) put_token(2'($urandom), 2'($urandom), pick_value());
		end_expr();
	endtask

	// result side: random stall before each beat, with stretches of none
	initial begin
		int gap;
		rsp.ready = 1'b0;
		rcv_calm  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 15) == 0)
				rcv_calm = ~rcv_calm;
			gap = rcv_calm ? 0 : $urandom_range(0, 10);
			if (gap != 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
		end
	end

	// watchdog: any accepted beat on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((tok.valid && tok.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("postfix_stack_evaluator test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n;
		int keep;
		int pick;
		arst_n    = 1'b0;
		tok.valid = 1'b0;
		tok.kind  = pse_pkg::KIND_PUSH;
		tok.op    = pse_pkg::OP_ADD;
		tok.value = '0;
		snd_calm  = 1'b0;
		sent      = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// end on an empty stack is malformed
		end_expr();
		// product of two maxima saturates high
		push_value(VAL_MAX);
		push_value(VAL_MAX);
		apply_op(pse_pkg::OP_MUL);
		end_expr();
		// difference below the minimum saturates low
		push_value(VAL_MIN);
		push_value(q_int(1));
		apply_op(pse_pkg::OP_SUB);
		end_expr();
		// minimum divided by minus one saturates high
		push_value(VAL_MIN);
		push_value(q_int(-1));
		apply_op(pse_pkg::OP_DIV);
		end_expr();
		// divide by zero, then an operand left over: divide status wins
		push_value(q_int(-3));
		push_value('0);
		apply_op(pse_pkg::OP_DIV);
		push_value(q_int(1));
		end_expr();
		// underflow is sticky: the later push is dropped
		push_value(q_int(1));
		apply_op(pse_pkg::OP_ADD);
		push_value(q_int(1));
		end_expr();
		// unused kind code leaves the stack alone
		push_value(q_int(7));
		put_token(KIND_UNUSED, pse_pkg::OP_DIV, VAL_MIN);
		end_expr();

		// let the pipeline run dry once before the random part
		hold_off();

		while (sent < TOKEN_GOAL) begin
			snd_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 15) == 0)
				hold_off();
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				full_stack_expr(0);
			end else if (pick < 6) begin
				full_stack_expr($urandom_range(1, 3));
			end else if (pick < 25) begin
				noise_expr($urandom_range(1, 8));
			end else begin
				// mostly short expressions, sometimes long ones
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
				keep = 1;
				if (n > 1 && $urandom_range(0, 5) == 0)
					keep = $urandom_range(2, (n < 4) ? n : 4);
				well_formed_expr(n, keep);
			end
		end
		tok.valid <= 1'b0;

		// everything sent: wait out the last results and any stray beat
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("postfix_stack_evaluator test passed");
		else
			$display("postfix_stack_evaluator test failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/pse_pkg.sv
rtl/pse_tok_if.sv
rtl/pse_rsp_if.sv
rtl/pse_ram.sv
rtl/pse_alu.sv
rtl/postfix_stack_evaluator.sv
sim/pse_result_checker.sv
sim/tb_postfix_stack_evaluator.sv
